/* rtl/bda_pkg.sv */
package bda_pkg;

    localparam int MIN_ORDER      = 5;
    localparam int MAX_ORDER      = 12;
    localparam int NLISTS         = MAX_ORDER - MIN_ORDER + 1;
    localparam int UNITS_PER_PAGE = 128;
    localparam int HDR_BYTES      = 24;
    localparam int PAGE_BYTES     = 4096;

    localparam logic [3:0] ORD_MIN = 4'd5;
    localparam logic [3:0] ORD_MAX = 4'd12;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_TOOBIG  = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // datapath micro-operations
    localparam logic [4:0] DP_NOP       = 5'd0;
    localparam logic [4:0] DP_CLR       = 5'd1;
    localparam logic [4:0] DP_LOAD      = 5'd2;
    localparam logic [4:0] DP_DEC       = 5'd3;
    localparam logic [4:0] DP_FTAG      = 5'd4;
    localparam logic [4:0] DP_SPLIT_SEL = 5'd5;
    localparam logic [4:0] DP_FINAL_SEL = 5'd6;
    localparam logic [4:0] DP_SET_V     = 5'd7;
    localparam logic [4:0] DP_SET_U     = 5'd8;
    localparam logic [4:0] DP_GRANT     = 5'd9;
    localparam logic [4:0] DP_BUD_RD    = 5'd10;
    localparam logic [4:0] DP_MERGE     = 5'd11;
    localparam logic [4:0] DP_FREE_PUSH = 5'd12;
    localparam logic [4:0] DP_ULK_RD    = 5'd13;
    localparam logic [4:0] DP_ULK_WR    = 5'd14;
    localparam logic [4:0] DP_PUSH1     = 5'd15;
    localparam logic [4:0] DP_PUSH2     = 5'd16;

    typedef struct packed {
        logic [4:0] op;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic too_big;
        logic found;
        logic full;
        logic addr_bad;
        logic tag_ok;
        logic bud_match;
        logic o_gt_want;
        logic o_lt_max;
        logic clr_last;
    } stat_t;

    function automatic logic [3:0] bit_len13(input logic [12:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 13; i++)
        begin
            if (v[i])
            begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

/* rtl/bda_dp.sv */
module bda_dp import bda_pkg::*; #(
    parameter int POOL_PAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        in_op,
    input  logic [11:0] in_size,
    input  logic [15:0] in_addr,
    output logic [1:0]  res_status,
    output logic [15:0] res_addr,
    output logic [3:0]  res_order
);

    localparam int UNITS = POOL_PAGES * UNITS_PER_PAGE;
    localparam int UW    = $clog2(UNITS);
    localparam int PW    = $clog2(POOL_PAGES + 1);
    localparam int LW    = UW + 1;

    logic [5:0]    tag_mem [UNITS];
    logic [LW-1:0] nxt_mem [UNITS];
    logic [LW-1:0] prv_mem [UNITS];

    logic [LW-1:0] head_reg [NLISTS];
    logic          op_reg;
    logic [3:0]    want_reg;
    logic          too_big_reg;
    logic [15:0]   addr_reg;
    logic [UW-1:0] u_reg;
    logic [UW-1:0] x_reg;
    logic [3:0]    o_reg;
    logic [3:0]    po_reg;
    logic [PW-1:0] pages_reg;
    logic [UW-1:0] clr_reg;
    logic [1:0]    status_reg;
    logic [15:0]   gaddr_reg;
    logic [3:0]    gorder_reg;

    logic [5:0]    tag_rd;
    logic [LW-1:0] nxt_rd;
    logic [LW-1:0] prv_rd;

    logic          tag_we;
    logic [UW-1:0] tag_wa;
    logic [5:0]    tag_wd;
    logic [UW-1:0] tag_ra;
    logic          nxt_we;
    logic [UW-1:0] nxt_wa;
    logic [LW-1:0] nxt_wd;
    logic          prv_we;
    logic [UW-1:0] prv_wa;
    logic [LW-1:0] prv_wd;

    logic [12:0]   need;
    logic [3:0]    want_calc;
    logic [2:0]    want_li;
    logic [2:0]    o_li;
    logic [2:0]    po_li;
    logic          found;
    logic [2:0]    found_li;
    logic          full;
    logic          addr_bad;
    logic [PW+6:0] unit_limit;
    logic [10:0]   unit_in;
    logic [UW-1:0] page_base;
    logic [UW-1:0] bud;
    logic [UW-1:0] half;
    logic [LW-1:0] po_head;

    assign need      = {1'b0, in_size} + 13'(HDR_BYTES);
    assign want_calc = (bit_len13(need) < ORD_MIN) ? ORD_MIN : bit_len13(need);
    assign want_li   = 3'(want_reg - ORD_MIN);
    assign o_li      = 3'(o_reg - ORD_MIN);
    assign po_li     = 3'(po_reg - ORD_MIN);
    assign po_head   = head_reg[po_li];
    assign unit_in   = addr_reg[15:5];
    assign unit_limit = {pages_reg, 7'd0};
    assign full      = (32'(pages_reg) >= 32'(POOL_PAGES));
    assign addr_bad  = (addr_reg[4:0] != 5'd0) || (32'(unit_in) >= 32'(unit_limit));
    assign page_base = UW'(unit_limit);
    assign bud       = u_reg ^ (UW'(1) << (o_reg - ORD_MIN));
    assign half      = UW'(1) << (o_reg - 4'd6);

    // lowest non-empty list at or above the wanted order
    always_comb
    begin
        found    = 1'b0;
        found_li = 3'd0;
        for (int i = NLISTS - 1; i >= 0; i--)
        begin
            if (!head_reg[i][UW] && (3'(i) >= want_li))
            begin
                found    = 1'b1;
                found_li = 3'(i);
            end
        end
    end

    assign stat.is_free   = op_reg;
    assign stat.too_big   = too_big_reg;
    assign stat.found     = found;
    assign stat.full      = full;
    assign stat.addr_bad  = addr_bad;
    assign stat.tag_ok    = !tag_rd[5] && !tag_rd[4]
                            && (tag_rd[3:0] >= ORD_MIN) && (tag_rd[3:0] <= ORD_MAX);
    assign stat.bud_match = (tag_rd == {2'b10, o_reg});
    assign stat.o_gt_want = (o_reg > want_reg);
    assign stat.o_lt_max  = (o_reg < ORD_MAX);
    assign stat.clr_last  = (clr_reg == UW'(UNITS - 1));

    always_comb
    begin
        tag_we = 1'b0;
        tag_wa = x_reg;
        tag_wd = 6'd0;
        tag_ra = bud;
        nxt_we = 1'b0;
        nxt_wa = x_reg;
        nxt_wd = po_head;
        prv_we = 1'b0;
        prv_wa = x_reg;
        prv_wd = {1'b1, UW'(po_li)};
        unique case (cmd.op)
            DP_CLR:
            begin
                tag_we = 1'b1;
                tag_wa = clr_reg;
            end
            DP_DEC:
            begin
                tag_ra = UW'(unit_in);
            end
            DP_GRANT:
            begin
                tag_we = 1'b1;
                tag_wa = u_reg;
                tag_wd = {2'b00, want_reg};
            end
            DP_MERGE:
            begin
                tag_we = 1'b1;
                tag_wa = (x_reg > u_reg) ? x_reg : u_reg;
            end
            DP_ULK_WR:
            begin
                nxt_we = !prv_rd[UW];
                nxt_wa = prv_rd[UW-1:0];
                nxt_wd = nxt_rd;
                prv_we = !nxt_rd[UW];
                prv_wa = nxt_rd[UW-1:0];
                prv_wd = prv_rd;
            end
            DP_PUSH1:
            begin
                tag_we = 1'b1;
                tag_wd = {2'b10, po_reg};
                nxt_we = 1'b1;
                prv_we = 1'b1;
            end
            DP_PUSH2:
            begin
                prv_we = !po_head[UW];
                prv_wa = po_head[UW-1:0];
                prv_wd = {1'b0, x_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_wa] <= tag_wd;
        end
        tag_rd <= tag_mem[tag_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        nxt_rd <= nxt_mem[x_reg];
    end

    always_ff @(posedge clk)
    begin
        if (prv_we)
        begin
            prv_mem[prv_wa] <= prv_wd;
        end
        prv_rd <= prv_mem[x_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NLISTS; i++)
            begin
                head_reg[i] <= {1'b1, UW'(0)};
            end
            pages_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                DP_CLR:
                begin
                    clr_reg <= clr_reg + UW'(1);
                end
                DP_DEC:
                begin
                    if (!op_reg && !too_big_reg && !found && !full)
                    begin
                        pages_reg <= pages_reg + PW'(1);
                    end
                end
                DP_ULK_WR:
                begin
                    if (prv_rd[UW])
                    begin
                        head_reg[prv_rd[2:0]] <= nxt_rd;
                    end
                end
                DP_PUSH2:
                begin
                    head_reg[po_li] <= {1'b0, x_reg};
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                op_reg      <= in_op;
                want_reg    <= want_calc;
                too_big_reg <= (need >= 13'(PAGE_BYTES));
                addr_reg    <= in_addr;
                status_reg  <= ST_OK;
                gaddr_reg   <= 16'd0;
                gorder_reg  <= 4'd0;
            end
            DP_DEC:
            begin
                if (op_reg == OP_FREE)
                begin
                    u_reg <= UW'(unit_in);
                    if (addr_bad)
                    begin
                        status_reg <= ST_BADFREE;
                    end
                end
                else if (too_big_reg)
                begin
                    status_reg <= ST_TOOBIG;
                end
                else if (found)
                begin
                    o_reg <= 4'(found_li) + ORD_MIN;
                end
                else if (full)
                begin
                    status_reg <= ST_NOMEM;
                end
                else
                begin
                    x_reg  <= page_base;
                    po_reg <= ORD_MAX;
                    o_reg  <= ORD_MAX;
                end
            end
            DP_FTAG:
            begin
                o_reg <= tag_rd[3:0];
                if (!stat.tag_ok)
                begin
                    status_reg <= ST_BADFREE;
                end
            end
            DP_SPLIT_SEL:
            begin
                u_reg <= head_reg[o_li][UW-1:0];
                x_reg <= head_reg[o_li][UW-1:0];
            end
            DP_FINAL_SEL:
            begin
                u_reg <= head_reg[want_li][UW-1:0];
                x_reg <= head_reg[want_li][UW-1:0];
            end
            DP_SET_V:
            begin
                x_reg  <= u_reg + half;
                po_reg <= o_reg - 4'd1;
            end
            DP_SET_U:
            begin
                x_reg  <= u_reg;
                po_reg <= o_reg - 4'd1;
                o_reg  <= o_reg - 4'd1;
            end
            DP_GRANT:
            begin
                gaddr_reg  <= 16'({u_reg, 5'd0});
                gorder_reg <= want_reg;
            end
            DP_BUD_RD:
            begin
                x_reg <= bud;
            end
            DP_MERGE:
            begin
                if (x_reg < u_reg)
                begin
                    u_reg <= x_reg;
                end
                o_reg <= o_reg + 4'd1;
            end
            DP_FREE_PUSH:
            begin
                x_reg  <= u_reg;
                po_reg <= o_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign res_status = status_reg;
    assign res_addr   = gaddr_reg;
    assign res_order  = gorder_reg;

endmodule

/* rtl/bda_ctrl.sv */
module bda_ctrl import bda_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  out_free,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  ready,
    output logic  done
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_DECODE    = 4'd2;
    localparam logic [3:0] S_FTAG      = 4'd3;
    localparam logic [3:0] S_SPLIT_CHK = 4'd4;
    localparam logic [3:0] S_SPLIT_V   = 4'd5;
    localparam logic [3:0] S_SPLIT_U   = 4'd6;
    localparam logic [3:0] S_GRANT     = 4'd7;
    localparam logic [3:0] S_MCHK      = 4'd8;
    localparam logic [3:0] S_MTST      = 4'd9;
    localparam logic [3:0] S_ULK1      = 4'd10;
    localparam logic [3:0] S_ULK2      = 4'd11;
    localparam logic [3:0] S_PSH1      = 4'd12;
    localparam logic [3:0] S_PSH2      = 4'd13;
    localparam logic [3:0] S_DONE      = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] ret_reg;
    logic [3:0] ret_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.op     = DP_NOP;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = DP_CLR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.op = DP_DEC;
                if (stat.is_free)
                begin
                    state_next = stat.addr_bad ? S_DONE : S_FTAG;
                end
                else if (stat.too_big)
                begin
                    state_next = S_DONE;
                end
                else if (stat.found)
                begin
                    state_next = S_SPLIT_CHK;
                end
                else if (stat.full)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PSH1;
                    ret_next   = S_SPLIT_CHK;
                end
            end
            S_FTAG:
            begin
                cmd.op     = DP_FTAG;
                state_next = stat.tag_ok ? S_MCHK : S_DONE;
            end
            S_SPLIT_CHK:
            begin
                state_next = S_ULK1;
                if (stat.o_gt_want)
                begin
                    cmd.op   = DP_SPLIT_SEL;
                    ret_next = S_SPLIT_V;
                end
                else
                begin
                    cmd.op   = DP_FINAL_SEL;
                    ret_next = S_GRANT;
                end
            end
            S_SPLIT_V:
            begin
                cmd.op     = DP_SET_V;
                state_next = S_PSH1;
                ret_next   = S_SPLIT_U;
            end
            S_SPLIT_U:
            begin
                cmd.op     = DP_SET_U;
                state_next = S_PSH1;
                ret_next   = S_SPLIT_CHK;
            end
            S_GRANT:
            begin
                cmd.op     = DP_GRANT;
                state_next = S_DONE;
            end
            S_MCHK:
            begin
                if (stat.o_lt_max)
                begin
                    cmd.op     = DP_BUD_RD;
                    state_next = S_MTST;
                end
                else
                begin
                    cmd.op     = DP_FREE_PUSH;
                    state_next = S_PSH1;
                    ret_next   = S_DONE;
                end
            end
            S_MTST:
            begin
                if (stat.bud_match)
                begin
                    cmd.op     = DP_MERGE;
                    state_next = S_ULK1;
                    ret_next   = S_MCHK;
                end
                else
                begin
                    cmd.op     = DP_FREE_PUSH;
                    state_next = S_PSH1;
                    ret_next   = S_DONE;
                end
            end
            S_ULK1:
            begin
                cmd.op     = DP_ULK_RD;
                state_next = S_ULK2;
            end
            S_ULK2:
            begin
                cmd.op     = DP_ULK_WR;
                state_next = ret_reg;
            end
            S_PSH1:
            begin
                cmd.op     = DP_PUSH1;
                state_next = S_PSH2;
            end
            S_PSH2:
            begin
                cmd.op     = DP_PUSH2;
                state_next = ret_reg;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign ready = (state_reg == S_IDLE);
    assign done  = (state_reg == S_DONE);

endmodule

/* rtl/buddy_allocator.sv */
// Buddy allocator over POOL_PAGES pages of 4096 bytes, handing out blocks of
// order 5 (32 bytes) to 12 (4096 bytes). Each request is one transfer in and
// one transfer out. Requests run one at a time through a state machine that
// drives a datapath of link and tag memories, one memory step per cycle:
// an allocate splits the lowest fitting free block down to the wanted order,
// first taking a fresh page when no free list can serve it, and a free merges
// the block with its free buddy as long as one is found. After reset the tag
// memory is cleared one entry per cycle, all POOL_PAGES * 128 entries, before
// the first transfer is taken. A result waiting at the output does not block
// the next request from being accepted; that request then holds in its last
// cycle until the output register is free.
module buddy_allocator import bda_pkg::*; #(
    parameter int POOL_PAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // req_size[11:0], block_addr[27:12], zero pad
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // granted_addr[15:0], granted_order[19:16], zero pad
    output logic [1:0]  m_tuser    // status
);

    cmd_t        cmd;
    stat_t       stat;
    logic        ready;
    logic        done;
    logic        out_free;
    logic [1:0]  res_status;
    logic [15:0] res_addr;
    logic [3:0]  res_order;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [15:0] out_addr_reg;
    logic [3:0]  out_order_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = ready;

    bda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .ready    (ready),
        .done     (done)
    );

    bda_dp #(
        .POOL_PAGES (POOL_PAGES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_size    (s_tdata[11:0]),
        .in_addr    (s_tdata[27:12]),
        .res_status (res_status),
        .res_addr   (res_addr),
        .res_order  (res_order)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // load the result when the output register is empty or its transfer leaves
    always_ff @(posedge clk)
    begin
        if (done && out_free)
        begin
            out_status_reg <= res_status;
            out_addr_reg   <= res_addr;
            out_order_reg  <= res_order;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'd0, out_order_reg, out_addr_reg};

    property p_fail_zero;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[19:0] == 20'd0);
    endproperty
    a_fail_zero: assert property (p_fail_zero)
        else $error("failed request carries a nonzero grant");

    property p_grant_aligned;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[19:16] != 4'd0)) |->
            ((m_tdata[19:16] >= ORD_MIN) && (m_tdata[19:16] <= ORD_MAX)
             && ((m_tdata[15:0] & ((16'd1 << m_tdata[19:16]) - 16'd1)) == 16'd0));
    endproperty
    a_grant_aligned: assert property (p_grant_aligned)
        else $error("grant order out of range or address misaligned");

    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("second request taken while one is in flight");

endmodule
